### design/msp_pkg.sv
// msp_pkg: widths, constants and stage payload types of the moving sphere pair contact time block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int FIELD_W    = 48;
  localparam int RAD_W      = 16;
  localparam int TIME_W     = 16;

  localparam int DW     = COORD_BITS + 1;
  localparam int RSUM_W = RAD_W + 1;
  localparam int RR_W   = 2 * RSUM_W;
  localparam int PW     = 2 * DW;
  localparam int SW     = ((PW > RR_W) ? PW : RR_W) + 2;
  localparam int NW     = SW - 1;
  localparam int HL     = (NW + 1) / 2;
  localparam int HH     = NW - HL;
  localparam int DDW    = 2 * NW;
  localparam int RW     = NW;
  localparam int RMW    = RW + 3;
  localparam int QRW    = NW + TIME_W;

  typedef struct packed {
    logic          ovl;
    logic          quit;
    logic [NW-1:0] nb;
    logic [NW-1:0] vv;
  } msp_ctl_t;

  typedef struct packed {
    msp_ctl_t       ctl;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    logic [DDW-1:0] d;
  } msp_sq_t;

  typedef struct packed {
    logic              ovl;
    logic              quit;
    logic              sat;
    logic [QRW-1:0]    rem;
    logic [QRW-1:0]    den;
    logic [TIME_W-1:0] q;
  } msp_dv_t;

endpackage
`default_nettype wire

### design/msp_front.sv
// msp_front: six registered stages forming offsets, dot products, c, b*b and a*c, and d
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none
module msp_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [msp_pkg::FIELD_W-1:0]  center_a,
  input  wire logic [msp_pkg::RAD_W-1:0]    radius_a,
  input  wire logic [msp_pkg::FIELD_W-1:0]  center_b,
  input  wire logic [msp_pkg::RAD_W-1:0]    radius_b,
  input  wire logic [msp_pkg::FIELD_W-1:0]  motion_a,
  input  wire logic [msp_pkg::FIELD_W-1:0]  motion_b,
  output logic                              dn_valid,
  output msp_pkg::msp_sq_t                  dn_data,
  input  wire logic                         dn_ready
);
  import msp_pkg::*;

  logic [6:1] v_r;
  logic [7:1] rdy;

  // stage 1
  logic signed [DW-1:0]     sd_r [3];
  logic signed [DW-1:0]     vd_r [3];
  logic [RSUM_W-1:0]        r_r;
  // stage 2
  logic signed [PW-1:0]     pss_r [3];
  logic signed [PW-1:0]     pvv_r [3];
  logic signed [PW-1:0]     pvs_r [3];
  logic [RR_W-1:0]          rr_r;
  // stage 3
  msp_ctl_t                 c3_r;
  logic [NW-1:0]            c_r;
  // stage 4
  msp_ctl_t                 c4_r;
  logic [2*HL-1:0]          bll_r, all_r;
  logic [HL+HH-1:0]         blh_r, alh_r, ahl_r;
  logic [2*HH-1:0]          bhh_r, ahh_r;
  // stage 5
  msp_ctl_t                 c5_r;
  logic [DDW-1:0]           bb_r, ac_r;
  // stage 6
  msp_sq_t                  s6_r;

  logic signed [SW-1:0]     ss, vv, vs, cc;
  msp_sq_t                  s6_nxt;

  always_comb begin
    rdy[7] = dn_ready;
    for (int k = 6; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign up_ready = rdy[1];
  assign dn_valid = v_r[6];
  assign dn_data  = s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= up_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        sd_r[i] <= signed'({center_b[i*COORD_BITS+COORD_BITS-1],
                            center_b[i*COORD_BITS +: COORD_BITS]})
                 - signed'({center_a[i*COORD_BITS+COORD_BITS-1],
                            center_a[i*COORD_BITS +: COORD_BITS]});
        vd_r[i] <= signed'({motion_b[i*COORD_BITS+COORD_BITS-1],
                            motion_b[i*COORD_BITS +: COORD_BITS]})
                 - signed'({motion_a[i*COORD_BITS+COORD_BITS-1],
                            motion_a[i*COORD_BITS +: COORD_BITS]});
      end
      r_r <= {1'b0, radius_a} + {1'b0, radius_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        pss_r[i] <= sd_r[i] * sd_r[i];
        pvv_r[i] <= vd_r[i] * vd_r[i];
        pvs_r[i] <= vd_r[i] * sd_r[i];
      end
      rr_r <= r_r * r_r;
    end
  end

  always_comb begin
    ss = SW'(pss_r[0]) + SW'(pss_r[1]) + SW'(pss_r[2]);
    vv = SW'(pvv_r[0]) + SW'(pvv_r[1]) + SW'(pvv_r[2]);
    vs = SW'(pvs_r[0]) + SW'(pvs_r[1]) + SW'(pvs_r[2]);
    cc = ss - signed'(SW'(rr_r));
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      c3_r.ovl  <= cc[SW-1];
      c3_r.quit <= (vv == '0) || !vs[SW-1];
      c3_r.nb   <= NW'(-vs);
      c3_r.vv   <= NW'(vv);
      c_r       <= NW'(cc);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      c4_r  <= c3_r;
      bll_r <= c3_r.nb[HL-1:0] * c3_r.nb[HL-1:0];
      blh_r <= c3_r.nb[HL-1:0] * c3_r.nb[NW-1:HL];
      bhh_r <= c3_r.nb[NW-1:HL] * c3_r.nb[NW-1:HL];
      all_r <= c3_r.vv[HL-1:0] * c_r[HL-1:0];
      alh_r <= c3_r.vv[HL-1:0] * c_r[NW-1:HL];
      ahl_r <= c3_r.vv[NW-1:HL] * c_r[HL-1:0];
      ahh_r <= c3_r.vv[NW-1:HL] * c_r[NW-1:HL];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      c5_r <= c4_r;
      bb_r <= (DDW'(bhh_r) << (2*HL)) + (DDW'(blh_r) << (HL+1)) + DDW'(bll_r);
      ac_r <= (DDW'(ahh_r) << (2*HL)) + ((DDW'(alh_r) + DDW'(ahl_r)) << HL)
            + DDW'(all_r);
    end
  end

  always_comb begin
    s6_nxt.ctl      = c5_r;
    s6_nxt.ctl.quit = c5_r.quit || (bb_r < ac_r);
    s6_nxt.rem      = '0;
    s6_nxt.root     = '0;
    s6_nxt.d        = bb_r - ac_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) s6_r <= s6_nxt;
  end
endmodule
`default_nettype wire

### design/msp_sqrt_cell.sv
// msp_sqrt_cell: one root digit of the integer square root, two radicand bits a cell
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none
module msp_sqrt_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  input  msp_pkg::msp_sq_t  up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output msp_pkg::msp_sq_t  dn_data,
  input  wire logic         dn_ready
);
  import msp_pkg::*;

  logic           v_r;
  msp_sq_t        d_r, d_nxt;
  logic [RMW-1:0] rem_sh, trial;
  logic           ge;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    rem_sh      = {up_data.rem[RMW-3:0], up_data.d[DDW-1 -: 2]};
    trial       = RMW'({up_data.root, 2'b01});
    ge          = rem_sh >= trial;
    d_nxt.ctl   = up_data.ctl;
    d_nxt.rem   = ge ? rem_sh - trial : rem_sh;
    d_nxt.root  = {up_data.root[RW-2:0], ge};
    d_nxt.d     = up_data.d << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) d_r <= d_nxt;
  end
endmodule
`default_nettype wire

### design/msp_div_cell.sv
// msp_div_cell: one quotient bit of the contact time division
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none
module msp_div_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  input  msp_pkg::msp_dv_t  up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output msp_pkg::msp_dv_t  dn_data,
  input  wire logic         dn_ready
);
  import msp_pkg::*;

  logic    v_r;
  msp_dv_t d_r, d_nxt;
  logic    ge;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    ge        = up_data.rem >= up_data.den;
    d_nxt     = up_data;
    d_nxt.rem = ge ? up_data.rem - up_data.den : up_data.rem;
    d_nxt.q   = {up_data.q[TIME_W-2:0], ge};
    d_nxt.den = up_data.den >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) d_r <= d_nxt;
  end
endmodule
`default_nettype wire

### design/moving_sphere_pair_contact_time_top.sv
// moving_sphere_pair_contact_time_top: swept sphere pair contact time pipeline
// depends on msp_pkg, msp_front, msp_sqrt_cell, msp_div_cell
//
// usage:
//   input channel in_* carries one sphere pair per item (centers, radii,
//   motions); result channel out_* returns hit, overlapping_at_start and
//   contact_time, one result per item, in order
//   throughput: one item per cycle unless out_stall backs up the chain; every
//   stage is a cell with its own valid bit, so bubbles collapse and a new item can enter each cycle
//   stages: 6 front stages, 35 square root cells, 1 saturation stage,
//   16 divider cells, 1 output register; the square root chain, one
//   cell per root bit, is the longest part
//   out_stall holds the output register; cells behind it keep filling and
//   in_stall rises only when every cell holds an item
//   reset empties all cells; no item is lost once accepted
`timescale 1ns / 1ps
`default_nettype none
module moving_sphere_pair_contact_time_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [msp_pkg::FIELD_W-1:0]  in_center_a,
  input  wire logic [msp_pkg::RAD_W-1:0]    in_radius_a,
  input  wire logic [msp_pkg::FIELD_W-1:0]  in_center_b,
  input  wire logic [msp_pkg::RAD_W-1:0]    in_radius_b,
  input  wire logic [msp_pkg::FIELD_W-1:0]  in_motion_a,
  input  wire logic [msp_pkg::FIELD_W-1:0]  in_motion_b,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_hit,
  output logic                              out_overlapping_at_start,
  output logic [msp_pkg::TIME_W-1:0]        out_contact_time
);
  import msp_pkg::*;

  logic    front_ready;
  logic    sq_v   [NW+1];
  logic    sq_rdy [NW+1];
  msp_sq_t sq_d   [NW+1];

  logic    dv_v   [TIME_W+1];
  logic    dv_rdy [TIME_W+1];
  msp_dv_t dv_d   [TIME_W+1];

  logic              qs_v_r;
  msp_dv_t           qs_r, qs_nxt;
  logic [QRW-1:0]    num;

  logic              out_v_r;
  logic              hit_r, ovl_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              out_rdy;

  assign in_stall = !front_ready;

  msp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .center_a (in_center_a),
    .radius_a (in_radius_a),
    .center_b (in_center_b),
    .radius_b (in_radius_b),
    .motion_a (in_motion_a),
    .motion_b (in_motion_b),
    .dn_valid (sq_v[0]),
    .dn_data  (sq_d[0]),
    .dn_ready (sq_rdy[0])
  );

  for (genvar k = 0; k < NW; k++) begin : g_sqrt
    msp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[k]),
      .up_data  (sq_d[k]),
      .up_ready (sq_rdy[k]),
      .dn_valid (sq_v[k+1]),
      .dn_data  (sq_d[k+1]),
      .dn_ready (sq_rdy[k+1])
    );
  end

  // saturation check and divider setup
  assign sq_rdy[NW] = !qs_v_r || dv_rdy[0];

  always_comb begin
    num        = QRW'(sq_d[NW].ctl.nb - sq_d[NW].root) << FRAC_BITS;
    qs_nxt.ovl  = sq_d[NW].ctl.ovl;
    qs_nxt.quit = sq_d[NW].ctl.quit;
    qs_nxt.sat  = num >= (QRW'(sq_d[NW].ctl.vv) << TIME_W);
    qs_nxt.rem  = num;
    qs_nxt.den  = QRW'(sq_d[NW].ctl.vv) << (TIME_W - 1);
    qs_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_v_r <= 1'b0;
    end else if (sq_rdy[NW]) begin
      qs_v_r <= sq_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[NW]) qs_r <= qs_nxt;
  end

  assign dv_v[0] = qs_v_r;
  assign dv_d[0] = qs_r;

  for (genvar k = 0; k < TIME_W; k++) begin : g_div
    msp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[k]),
      .up_data  (dv_d[k]),
      .up_ready (dv_rdy[k]),
      .dn_valid (dv_v[k+1]),
      .dn_data  (dv_d[k+1]),
      .dn_ready (dv_rdy[k+1])
    );
  end

  // output register
  assign out_rdy        = !out_v_r || !out_stall;
  assign dv_rdy[TIME_W] = out_rdy;

  always_comb begin
    if (dv_d[TIME_W].ovl || dv_d[TIME_W].quit) begin
      time_nxt = '0;
    end else if (dv_d[TIME_W].sat) begin
      time_nxt = '1;
    end else begin
      time_nxt = dv_d[TIME_W].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= dv_v[TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      hit_r  <= dv_d[TIME_W].ovl || !dv_d[TIME_W].quit;
      ovl_r  <= dv_d[TIME_W].ovl;
      time_r <= time_nxt;
    end
  end

  assign out_valid                = out_v_r;
  assign out_hit                  = hit_r;
  assign out_overlapping_at_start = ovl_r;
  assign out_contact_time         = time_r;
endmodule
`default_nettype wire

### test/moving_sphere_pair_contact_time_top_test.sv
// moving_sphere_pair_contact_time_top_test: self-checking bench for the swept sphere pair
// contact time pipeline; directed table then random sphere pairs, checked by a local predictor
// depends on msp_pkg and moving_sphere_pair_contact_time_top
`timescale 1ns / 1ps
module moving_sphere_pair_contact_time_top_test;
  import msp_pkg::*;

  localparam int LATENCY   = 59;
  localparam int N_RANDOM  = 1230;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic [FIELD_W-1:0] ca;
    logic [RAD_W-1:0]   ra;
    logic [FIELD_W-1:0] cb;
    logic [RAD_W-1:0]   rb;
    logic [FIELD_W-1:0] ma;
    logic [FIELD_W-1:0] mb;
  } pair_t;

  typedef struct packed {
    logic              hit;
    logic              ovl;
    logic [TIME_W-1:0] t;
  } contact_t;

  typedef struct packed {
    pair_t    p;
    logic     known;
    contact_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_hit, out_ovl;
  logic [TIME_W-1:0] out_time;
  pair_t cur = '0;

  contact_t expected_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_long = 1'b0;

  always #2 clk = ~clk;

  moving_sphere_pair_contact_time_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_a(cur.ca), .in_radius_a(cur.ra),
    .in_center_b(cur.cb), .in_radius_b(cur.rb),
    .in_motion_a(cur.ma), .in_motion_b(cur.mb),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_overlapping_at_start(out_ovl),
    .out_contact_time(out_time)
  );

  function automatic logic signed [127:0] comp(logic [FIELD_W-1:0] f, int k);
    logic signed [COORD_BITS-1:0] v;
    v = f[k*COORD_BITS +: COORD_BITS];
    return 128'(v);
  endfunction

  function automatic contact_t contact_time_of(pair_t p);
    logic signed [127:0] s, v, ss, vv, vs, r, c, d, nb, sq, cand, tq;
    contact_t res;
    ss = 0; vv = 0; vs = 0;
    for (int k = 0; k < 3; k++) begin
      s = comp(p.cb, k) - comp(p.ca, k);
      v = comp(p.mb, k) - comp(p.ma, k);
      ss += s * s;
      vv += v * v;
      vs += v * s;
    end
    r = 128'(p.ra) + 128'(p.rb);
    c = ss - r * r;
    res = '0;
    if (c < 0) begin
      res.hit = 1'b1;
      res.ovl = 1'b1;
      return res;
    end
    if (vv == 0 || vs >= 0) return res;
    nb = -vs;
    d = nb * nb - vv * c;
    if (d < 0) return res;
    sq = 0;
    for (int b = 47; b >= 0; b--) begin
      cand = sq | (128'sd1 << b);
      if (cand * cand <= d) sq = cand;
    end
    tq = ((nb - sq) <<< FRAC_BITS) / vv;
    res.hit = 1'b1;
    res.t = (tq > 65535) ? 16'hFFFF : tq[15:0];
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    logic [15:0] a, b, c;
    a = 16'(x); b = 16'(y); c = 16'(z);
    return {c, b, a};
  endfunction

  function automatic logic [FIELD_W-1:0] near_field(int span);
    return pack3($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                 $urandom_range(2*span) - span);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(9);
    if (mode < 2) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      p.ca = near_field(2000);
      p.cb = near_field(2000);
      p.ra = 16'($urandom_range(1200));
      p.rb = 16'($urandom_range(1200));
      p.ma = near_field(mode < 5 ? 600 : 3000);
      p.mb = near_field(mode < 5 ? 600 : 3000);
      if (mode == 9) p.mb = p.ma;
      if (mode == 8) begin
        p.ma = pack3(0, 0, 0);
        p.mb = pack3(-(int'($signed(p.cb[15:0])) - int'($signed(p.ca[15:0]))), 0, 0);
      end
    end
    return p;
  endfunction

  row_t table_rows[$];

  task automatic send(pair_t p);
    cur <= p;
    in_valid <= 1'b1;
    expected_q = {expected_q, contact_time_of(p)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  initial begin
    row_t rw;
    contact_t z;
    z = '0;
    rw.known = 1'b1;
    rw.p = '0; rw.r = '{1'b0, 1'b0, 16'd0}; table_rows = {table_rows, rw};
    rw.p = '0; rw.p.ra = 16'd1; rw.r = '{1'b1, 1'b1, 16'd0}; table_rows = {table_rows, rw};
    rw.p = '1; rw.r = '{1'b1, 1'b1, 16'd0}; table_rows = {table_rows, rw};
    rw.p = '0; rw.p.cb = pack3(1000, 0, 0); rw.r = z; table_rows = {table_rows, rw};
    rw.p.mb = pack3(100, 0, 0); rw.r = z; table_rows = {table_rows, rw};
    rw.p.mb = pack3(0, 0, -256); rw.p.ma = pack3(0, 0, -256); rw.r = z;
    table_rows = {table_rows, rw};
    rw.known = 1'b0;
    rw.p = '0; rw.p.cb = pack3(1024, 0, 0); rw.p.mb = pack3(-512, 0, 0);
    table_rows = {table_rows, rw};
    rw.p.ra = 16'd256; table_rows = {table_rows, rw};
    rw.p.mb = pack3(-1, 0, 0); table_rows = {table_rows, rw};
    rw.p.ra = '0; rw.p.cb = pack3(32767, 32767, 32767);
    rw.p.ca = pack3(-32768, -32768, -32768); rw.p.ma = pack3(32767, 32767, 32767);
    rw.p.mb = pack3(-32768, -32768, -32768); table_rows = {table_rows, rw};
    rw.p.ra = 16'hFFFF; rw.p.rb = 16'hFFFF; table_rows = {table_rows, rw};
    rw.p.ra = '0; rw.p.rb = 16'd10; rw.p.ca = pack3(0, 0, 0);
    rw.p.cb = pack3(1000, 500, 0); rw.p.mb = pack3(-300, 0, 0); rw.p.ma = '0;
    table_rows = {table_rows, rw};
    rw.p.cb = pack3(0, -700, 300); rw.p.mb = pack3(0, 690, -310);
    table_rows = {table_rows, rw};
    rw.p = '1; rw.p.ca = '0; rw.p.ra = '0; rw.p.rb = '0; table_rows = {table_rows, rw};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].known && table_rows[i].r != contact_time_of(table_rows[i].p)) begin
        $display("table row %0d disagrees with predictor", i);
        mismatches++;
      end
      send(table_rows[i].p);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_long = 1'b1;
      if (n > N_RANDOM - 150) quiet = 1'b1;
      send(random_pair());
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long <= 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    contact_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item hit=%0b", out_hit);
      end else begin
        want = expected_q.pop_front();
        if (want.hit !== out_hit || want.ovl !== out_ovl || want.t !== out_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp hit=%0b ovl=%0b t=%0d got hit=%0b ovl=%0b t=%0d",
                     want.hit, want.ovl, want.t, out_hit, out_ovl, out_time);
        end
      end
    end
  end
endmodule
